>>> rtl/precedence_reach_matrix_assert.svh
// Assertion macros for the precedence reach matrix RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef PRECEDENCE_REACH_MATRIX_ASSERT_SVH
`define PRECEDENCE_REACH_MATRIX_ASSERT_SVH

// same-cycle implication
`define PRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/prm_pkg.sv
// Shared types and constants for the precedence reach matrix.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

  localparam int NODE_W   = 7;
  localparam int CHUNK_W  = 16;
  localparam int CHUNK_IW = 4;

  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic                hit;
    logic [CHUNK_IW-1:0] off;
  } pick_t;

endpackage

`default_nettype wire

>>> rtl/prm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/prm_pick.sv
// Lowest-set-bit finder over one frontier chunk.
// Depends on prm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prm_pick (
  input  logic [prm_pkg::CHUNK_W-1:0] chunk,
  output prm_pkg::pick_t              pick
);
  import prm_pkg::*;

  always_comb begin
    pick.hit = |chunk;
    pick.off = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        pick.off = CHUNK_IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/precedence_reach_matrix.sv
// Channel  Dir  Signals                                 Handshake
// in       in   in_cmd, in_from_node, in_to_node        in_valid / in_ready
// out      out  out_has_prec                            out_valid / out_ready
//
// Query: to_node's row is read through the RAM port; its from_node bit is the result.
// Add: to_node's row is read, then the walk takes frontier nodes chunk by chunk
//   and reads each one's row to expand it, skipping to_node itself; the single
//   RAM read port sets the pace.
// Clear: every row is written with zeros, one row per cycle.
// After reset the same sweep runs before in_ready rises.
// in_ready is high only between commands; a result waits in the output register.
// Depends on prm_pkg, prm_ram, prm_pick and precedence_reach_matrix_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "precedence_reach_matrix_assert.svh"

module precedence_reach_matrix #(
  parameter int NODES = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [prm_pkg::NODE_W-1:0] in_from_node,
  input  logic [prm_pkg::NODE_W-1:0] in_to_node,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_has_prec
);
  import prm_pkg::*;

  localparam int IW  = $clog2(NODES);
  localparam int NCH = (NODES + CHUNK_W - 1) / CHUNK_W;
  localparam int PW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int FIW = PW + CHUNK_IW;
  localparam int FW  = (1 << PW) * CHUNK_W;
  localparam logic [IW-1:0] LAST_ROW = IW'(NODES - 1);
  localparam logic [PW-1:0] LAST_CH  = PW'(NCH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_QRD, S_ROW, S_SCAN, S_EXP, S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [IW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             clr_resp_r, clr_resp_nxt;
  logic [IW-1:0]    from_r, from_nxt;
  logic [IW-1:0]    to_r, to_nxt;
  logic [NODES-1:0] row_r, row_nxt;
  logic [FW-1:0]    frontier_r, frontier_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_has_prec_r, out_has_prec_nxt;

  logic             mem_wr_en;
  logic [IW-1:0]    mem_wr_addr;
  logic [NODES-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IW-1:0]    mem_rd_addr;
  logic [NODES-1:0] mem_rd_data;

  logic [FIW-1:0]   chunk_base;
  logic [FIW-1:0]   node_full;
  logic [IW-1:0]    node_idx;
  logic [NODES-1:0] fresh;
  logic             in_range;
  pick_t            pick;

  prm_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_matrix (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign chunk_base = {ptr_r, {CHUNK_IW{1'b0}}};

  prm_pick u_pick (
    .chunk(frontier_r[chunk_base +: CHUNK_W]),
    .pick (pick)
  );

  assign node_full = {ptr_r, pick.off};
  assign node_idx  = IW'(node_full);
  assign fresh     = mem_rd_data & ~row_r;
  assign in_range  = (32'(in_from_node) < NODES) && (32'(in_to_node) < NODES);

  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    clr_resp_nxt     = clr_resp_r;
    from_nxt         = from_r;
    to_nxt           = to_r;
    row_nxt          = row_r;
    frontier_nxt     = frontier_r;
    ptr_nxt          = ptr_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_has_prec_nxt = out_has_prec_r;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = clr_cnt_r;
    mem_wr_data      = '0;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = IW'(in_to_node);

    case (state_r)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          clr_cnt_nxt  = '0;
          clr_resp_nxt = 1'b0;
          state_nxt    = clr_resp_r ? S_RESP : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          from_nxt  = IW'(in_from_node);
          to_nxt    = IW'(in_to_node);
          res_nxt   = 1'b0;
          state_nxt = S_RESP;
          case (in_cmd)
            CMD_QUERY: begin
              if (in_range && (in_from_node != in_to_node)) begin
                mem_rd_en = 1'b1;
                state_nxt = S_QRD;
              end
            end
            CMD_ADD: begin
              if (in_range) begin
                mem_rd_en = 1'b1;
                state_nxt = S_ROW;
              end
            end
            CMD_CLEAR: begin
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_QRD: begin
        res_nxt   = mem_rd_data[from_r];
        state_nxt = S_RESP;
      end
      S_ROW: begin
        row_nxt                     = mem_rd_data;
        row_nxt[from_r]             = 1'b1;
        frontier_nxt                = '0;
        frontier_nxt[FIW'(from_r)]  = 1'b1;
        ptr_nxt                     = '0;
        state_nxt                   = S_SCAN;
      end
      S_SCAN: begin
        if (frontier_r == '0) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = to_r;
          mem_wr_data = row_r;
          state_nxt   = S_RESP;
        end else if (pick.hit) begin
          frontier_nxt[node_full] = 1'b0;
          // to_node's own row is the visited set: nothing to expand
          if (node_idx != to_r) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = node_idx;
            state_nxt   = S_EXP;
          end
        end else begin
          ptr_nxt = (ptr_r == LAST_CH) ? '0 : ptr_r + 1'b1;
        end
      end
      S_EXP: begin
        row_nxt      = row_r | fresh;
        frontier_nxt = frontier_r | FW'(fresh);
        state_nxt    = S_SCAN;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_has_prec_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      clr_resp_r     <= clr_resp_nxt;
      out_valid_r    <= out_valid_nxt;
      out_has_prec_r <= out_has_prec_nxt;
      from_r         <= from_nxt;
      to_r           <= to_nxt;
      row_r          <= row_nxt;
      frontier_r     <= frontier_nxt;
      ptr_r          <= ptr_nxt;
      res_r          <= res_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_has_prec = out_has_prec_r;

  `PRM_ASSERT_IMP(a_beat_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP,
                  "result beat loaded outside response state")
  `PRM_ASSERT_IMP(a_row_has_from, state_r == S_SCAN, row_r[from_r],
                  "walk row lost the added predecessor")
  `PRM_ASSERT_IMP(a_walk_end_write, (state_r == S_SCAN) && (frontier_r == '0),
                  mem_wr_en && (mem_wr_addr == to_r), "walk end without row write-back")
  `PRM_ASSERT_NXT(a_sweep_len, (state_r == S_CLEAR) && (clr_cnt_r != LAST_ROW),
                  state_r == S_CLEAR, "clear sweep left early")

endmodule

`default_nettype wire
